### sv/eci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eci_pkg
// Shared types and constants of the easing curve interpolator.
// ----------------------------------------------------------------------------
package eci_pkg;

   localparam int SEL_W   = 4;
   localparam int VALUE_W = 32;

   // curve selector codes, unused codes fall back to linear
   typedef enum logic [SEL_W-1:0] {
      EASE_LINEAR      = 4'd0,
      EASE_CUBIC_IN    = 4'd1,
      EASE_CUBIC_OUT   = 4'd2,
      EASE_CUBIC_INOUT = 4'd3,
      EASE_QUAD_IN     = 4'd4,
      EASE_QUAD_OUT    = 4'd5,
      EASE_QUAD_INOUT  = 4'd6,
      EASE_BOUNCE_IN   = 4'd7,
      EASE_BOUNCE_OUT  = 4'd8
   } ease_sel_type;

   // load enables of the curve pipeline stages
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } curve_en_type;

endpackage
`default_nettype wire

### sv/eci_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eci_req_if
// Request channel: progress, curve selector, start and end value.
// ----------------------------------------------------------------------------
interface eci_req_if #(parameter int FRAC_BITS = 16);
   import eci_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [FRAC_BITS:0]        progress;
   logic [SEL_W-1:0]          easing_type;
   logic signed [VALUE_W-1:0] from_value;
   logic signed [VALUE_W-1:0] to_value;

   modport source (output valid, progress, easing_type, from_value, to_value,
                   input ready);
   modport sink (input valid, progress, easing_type, from_value, to_value,
                 output ready);
endinterface
`default_nettype wire

### sv/eci_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eci_rsp_if
// Response channel: eased progress and interpolated value.
// ----------------------------------------------------------------------------
interface eci_rsp_if #(parameter int FRAC_BITS = 16);
   import eci_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [FRAC_BITS:0]        eased_progress;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, eased_progress, value, input ready);
   modport sink (input valid, eased_progress, value, output ready);
endinterface
`default_nettype wire

### sv/eci_curve.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eci_curve
// Four stage easing curve datapath: operand select, first product,
// shift and second product, combine and clamp.
// ----------------------------------------------------------------------------
module eci_curve #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  eci_pkg::curve_en_type     stage_en,
   input  logic [FRAC_BITS:0]        progress_in,
   input  logic [eci_pkg::SEL_W-1:0] easing_in,
   output logic [FRAC_BITS:0]        eased_out
);
   import eci_pkg::*;

   localparam int TW = FRAC_BITS + 1;
   localparam int OW = FRAC_BITS + 4;
   localparam int IW = FRAC_BITS + 7;
   localparam int PW = 2 * OW;
   localparam int EW = OW + 2;

   localparam logic signed [IW-1:0] ONE_I   = IW'(64'sd1 << FRAC_BITS);
   localparam logic signed [IW-1:0] ONE2_I  = IW'(64'sd2 << FRAC_BITS);
   localparam logic signed [IW-1:0] ONE4_I  = IW'(64'sd4 << FRAC_BITS);
   localparam logic signed [IW-1:0] ONE6_I  = IW'(64'sd6 << FRAC_BITS);
   localparam logic signed [IW-1:0] ONE8_I  = IW'(64'sd8 << FRAC_BITS);
   localparam logic signed [IW-1:0] ONE9_I  = IW'(64'sd9 << FRAC_BITS);
   localparam logic signed [IW-1:0] ONE10_I = IW'(64'sd10 << FRAC_BITS);
   localparam logic signed [IW-1:0] ONE21_I = IW'(64'sd21 << FRAC_BITS);
   localparam logic signed [EW-1:0] ONE_E   = EW'(64'sd1 << FRAC_BITS);

   localparam logic [TW-1:0] ONE_T   = TW'(64'd1 << FRAC_BITS);
   localparam logic [TW-1:0] HALF_T  = TW'(64'd1 << (FRAC_BITS - 1));
   localparam logic [TW-1:0] OFF3_T  = TW'((64'd3 << FRAC_BITS) / 4);
   localparam logic [TW-1:0] OFF15_T = TW'((64'd15 << FRAC_BITS) / 16);
   localparam logic [TW-1:0] OFF63_T = TW'((64'd63 << FRAC_BITS) / 64);

   typedef enum logic [2:0] {
      SHR_F  = 3'b001,
      SHR_F4 = 3'b010,
      SHR_F6 = 3'b100
   } shr_type;

   // stage 2 operand select
   ease_sel_type          sel_c;
   logic signed [IW-1:0]  t_w, f_w, u_w, bt_w, b11_w, d_w, x_w, y_w, z_w;
   logic [TW-1:0]         off_c;
   shr_type               bshr_c, shr_c;
   logic                  half_c;

   logic signed [OW-1:0]  x_ff, y_ff, z2_ff;
   ease_sel_type          sel2_ff;
   logic                  half2_ff;
   logic [TW-1:0]         t2_ff, off2_ff;
   shr_type               shr2_ff;

   assign sel_c = ease_sel_type'(easing_in);

   always_comb begin
      t_w    = signed'(IW'(progress_in));
      f_w    = t_w - ONE_I;
      u_w    = ONE_I - t_w;
      bt_w   = (sel_c == EASE_BOUNCE_IN) ? u_w : t_w;
      b11_w  = (bt_w <<< 3) + (bt_w <<< 1) + bt_w;
      half_c = progress_in < HALF_T;

      // bounce segment
      d_w    = b11_w;
      bshr_c = SHR_F4;
      off_c  = '0;
      if (b11_w < ONE4_I) begin
         d_w = b11_w;
      end else if (b11_w < ONE8_I) begin
         d_w   = b11_w - ONE6_I;
         off_c = OFF3_T;
      end else if (b11_w < ONE10_I) begin
         d_w   = b11_w - ONE9_I;
         off_c = OFF15_T;
      end else begin
         d_w    = (b11_w <<< 1) - ONE21_I;
         bshr_c = SHR_F6;
         off_c  = OFF63_T;
      end

      x_w   = t_w;
      y_w   = t_w;
      z_w   = t_w;
      shr_c = SHR_F;
      case (sel_c) inside
         EASE_CUBIC_OUT: begin
            x_w = f_w;
            y_w = f_w;
            z_w = f_w;
         end
         EASE_CUBIC_INOUT: begin
            if (!half_c) begin
               x_w = f_w;
               y_w = f_w <<< 1;
               z_w = f_w <<< 1;
            end
         end
         EASE_QUAD_OUT: begin
            y_w = ONE2_I - t_w;
         end
         EASE_QUAD_INOUT: begin
            if (!half_c) begin
               x_w = ONE4_I - (t_w <<< 1);
            end
         end
         EASE_BOUNCE_IN, EASE_BOUNCE_OUT: begin
            x_w   = d_w;
            y_w   = d_w;
            shr_c = bshr_c;
         end
         default: begin
            x_w = t_w;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         x_ff     <= x_w[OW-1:0];
         y_ff     <= y_w[OW-1:0];
         z2_ff    <= z_w[OW-1:0];
         sel2_ff  <= sel_c;
         half2_ff <= half_c;
         t2_ff    <= progress_in;
         off2_ff  <= off_c;
         shr2_ff  <= shr_c;
      end
   end

   // stage 3 first product
   logic signed [PW-1:0]  prod1_ff;
   logic signed [OW-1:0]  z3_ff;
   ease_sel_type          sel3_ff;
   logic                  half3_ff;
   logic [TW-1:0]         t3_ff, off3_ff;
   shr_type               shr3_ff;

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         prod1_ff <= PW'(x_ff) * PW'(y_ff);
         z3_ff    <= z2_ff;
         sel3_ff  <= sel2_ff;
         half3_ff <= half2_ff;
         t3_ff    <= t2_ff;
         off3_ff  <= off2_ff;
         shr3_ff  <= shr2_ff;
      end
   end

   // stage 4 floor shift and second product
   logic signed [PW-1:0]  sh1_c;
   logic signed [OW-1:0]  m1_c;
   logic signed [OW-1:0]  m1_ff;
   logic signed [PW-1:0]  prod2_ff;
   ease_sel_type          sel4_ff;
   logic                  half4_ff;
   logic [TW-1:0]         t4_ff, off4_ff;

   always_comb begin
      unique case (shr3_ff)
         SHR_F:   sh1_c = prod1_ff >>> FRAC_BITS;
         SHR_F4:  sh1_c = prod1_ff >>> (FRAC_BITS + 4);
         SHR_F6:  sh1_c = prod1_ff >>> (FRAC_BITS + 6);
         default: sh1_c = prod1_ff >>> FRAC_BITS;
      endcase
      m1_c = sh1_c[OW-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         m1_ff    <= m1_c;
         prod2_ff <= PW'(m1_c) * PW'(z3_ff);
         sel4_ff  <= sel3_ff;
         half4_ff <= half3_ff;
         t4_ff    <= t3_ff;
         off4_ff  <= off3_ff;
      end
   end

   // stage 5 combine and clamp
   logic signed [PW-1:0] sh2_c;
   logic signed [EW-1:0] m1e_c, m2e_c, offe_c, te_c, eraw_c;
   logic [TW-1:0]        eased_c;
   logic [TW-1:0]        eased_ff;

   always_comb begin
      sh2_c  = prod2_ff >>> FRAC_BITS;
      m2e_c  = EW'(signed'(sh2_c[OW-1:0]));
      m1e_c  = EW'(m1_ff);
      offe_c = signed'(EW'(off4_ff));
      te_c   = signed'(EW'(t4_ff));
      case (sel4_ff) inside
         EASE_CUBIC_IN:    eraw_c = m2e_c;
         EASE_CUBIC_OUT:   eraw_c = m2e_c + ONE_E;
         EASE_CUBIC_INOUT: eraw_c = half4_ff ? (m2e_c <<< 2) : (m2e_c + ONE_E);
         EASE_QUAD_IN, EASE_QUAD_OUT: eraw_c = m1e_c;
         EASE_QUAD_INOUT:  eraw_c = half4_ff ? (m1e_c <<< 1) : (m1e_c - ONE_E);
         EASE_BOUNCE_IN:   eraw_c = ONE_E - (m1e_c + offe_c);
         EASE_BOUNCE_OUT:  eraw_c = m1e_c + offe_c;
         default:          eraw_c = te_c;
      endcase
      if (eraw_c < 0) begin
         eased_c = '0;
      end else if (eraw_c > ONE_E) begin
         eased_c = ONE_T;
      end else begin
         eased_c = eraw_c[TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s5) begin
         eased_ff <= eased_c;
      end
   end

   assign eased_out = eased_ff;

endmodule
`default_nettype wire

### sv/easing_curve_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// easing_curve_interpolator
// Eases a progress value through a selectable curve and interpolates
// between a start and an end value.
// ----------------------------------------------------------------------------
// A request enters in any cycle in which req.ready is high and its response
// appears once it has passed through every stage register; the pipeline takes
// one request per cycle unless stalled, with no dependence between requests.
// The depth is set by the three chained multiplications (curve square, curve
// cube, value scaling), each followed by a register. A stall on rsp.ready
// holds only the stages that are full, so empty stages keep filling and
// req.ready falls only once all seven stages hold a request.
module easing_curve_interpolator #(
   parameter int FRAC_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   eci_req_if.sink  req,
   eci_rsp_if.source rsp
);
   import eci_pkg::*;

   localparam int NSTAGE = 7;
   localparam int TW     = FRAC_BITS + 1;
   localparam int DW     = VALUE_W + 1;
   localparam int PW3    = DW + TW + 1;

   localparam logic [TW-1:0] ONE_T = TW'(64'd1 << FRAC_BITS);

   logic [NSTAGE:1] valid_ff, valid_in;
   logic [NSTAGE:1] en;
   curve_en_type    curve_en;

   // stage enables, a stage moves when empty or when the next one moves
   always_comb begin
      en[NSTAGE] = !valid_ff[NSTAGE] || rsp.ready;
      for (int k = NSTAGE - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[1] = en[1] ? req.valid : valid_ff[1];
      for (int k = 2; k <= NSTAGE; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
      curve_en.s2 = en[2];
      curve_en.s3 = en[3];
      curve_en.s4 = en[4];
      curve_en.s5 = en[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req.ready = en[1];
   assign rsp.valid = valid_ff[NSTAGE];

   // stage 1 input register with saturation
   logic [TW-1:0]             t1_ff;
   logic [SEL_W-1:0]          sel1_ff;
   logic signed [VALUE_W-1:0] a1_ff, b1_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         t1_ff   <= (req.progress > ONE_T) ? ONE_T : req.progress;
         sel1_ff <= req.easing_type;
         a1_ff   <= req.from_value;
         b1_ff   <= req.to_value;
      end
   end

   // stages 2 to 5 curve datapath
   logic [TW-1:0] eased_c;

   eci_curve #(
      .FRAC_BITS (FRAC_BITS)
   ) u_curve (
      .clock       (clock),
      .stage_en    (curve_en),
      .progress_in (t1_ff),
      .easing_in   (sel1_ff),
      .eased_out   (eased_c)
   );

   // start value and span travel beside the curve
   logic signed [VALUE_W-1:0] a_ff [2:5];
   logic signed [DW-1:0]      diff_ff [2:5];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         a_ff[2]    <= a1_ff;
         diff_ff[2] <= DW'(b1_ff) - DW'(a1_ff);
      end
      for (int k = 3; k <= 5; k++) begin
         if (en[k]) begin
            a_ff[k]    <= a_ff[k-1];
            diff_ff[k] <= diff_ff[k-1];
         end
      end
   end

   // stage 6 span times eased progress
   logic signed [PW3-1:0]     prod_ff;
   logic signed [VALUE_W-1:0] a6_ff;
   logic [TW-1:0]             eased6_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         prod_ff   <= PW3'(diff_ff[5]) * PW3'(signed'({1'b0, eased_c}));
         a6_ff     <= a_ff[5];
         eased6_ff <= eased_c;
      end
   end

   // stage 7 floor shift and offset
   logic signed [VALUE_W-1:0] value_ff;
   logic [TW-1:0]             eased7_ff;

   always_ff @(posedge clock) begin
      if (en[7]) begin
         value_ff  <= a6_ff + signed'(prod_ff[FRAC_BITS +: VALUE_W]);
         eased7_ff <= eased6_ff;
      end
   end

   assign rsp.eased_progress = eased7_ff;
   assign rsp.value          = value_ff;

   // pipeline empties on reset
   assert property (@(posedge clock) reset |=> valid_ff == '0)
      else $error("pipeline not empty after reset");

   // eased progress never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.eased_progress <= ONE_T)
      else $error("eased progress above one");

   // back pressure only when every stage is full
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (&valid_ff))
      else $error("request stalled with an empty stage");

   // accepted request lands in stage one
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> valid_ff[1])
      else $error("accepted request lost at entry");

endmodule
`default_nettype wire
